// ===== rtl/core/gsv_pkg.sv =====
package gsv_pkg;

    // config port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_P       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER_Q         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR_A     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_SECRET_KEY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_PUBLIC_KEY = 3'd4;

    // datapath commands issued by the controller
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_POW_A_K,
        CMD_POW_A_U1,
        CMD_POW_Y_U2,
        CMD_POW_MUL,
        CMD_POW_SQR,
        CMD_R_RED,
        CMD_HQ,
        CMD_T1,
        CMD_T2,
        CMD_SRCH_INIT,
        CMD_SRCH_STEP,
        CMD_U1,
        CMD_U2,
        CMD_V,
        CMD_VQ,
        CMD_FIN_SIGN,
        CMD_FIN_RETRY,
        CMD_FIN_VFAIL,
        CMD_FIN_VER
    } t_cmd;

    // datapath status back to the controller
    typedef struct packed {
        logic done;
        logic exp_lsb;
        logic exp_done;
        logic q_zero;
        logic q_one;
        logic ver_bad;
        logic t_one;
        logic w_last;
        logic action;
    } t_status;

endpackage

// ===== rtl/core/gsv_datapath.sv =====
module gsv_datapath #(
    parameter int P_WIDTH = 31,
    parameter int Q_WIDTH = 11
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gsv_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gsv_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_load,
    input  logic                             i_action,
    input  logic [7:0]                       i_h,
    input  logic [Q_WIDTH-1:0]               i_k,
    input  logic [31:0]                      i_cr,
    input  logic [31:0]                      i_cs,
    input  gsv_pkg::t_cmd                    i_cmd,
    output gsv_pkg::t_status                 o_status,
    output logic [Q_WIDTH-1:0]               o_out_r,
    output logic [Q_WIDTH-1:0]               o_out_s,
    output logic                             o_retry,
    output logic                             o_ok
);
    import gsv_pkg::*;

    localparam int DW  = (P_WIDTH > Q_WIDTH) ? P_WIDTH : Q_WIDTH;
    localparam int MCW = $clog2(DW);
    localparam int ECW = $clog2(Q_WIDTH + 1);

    // configuration
    logic [P_WIDTH-1:0] r_p, r_a, r_y;
    logic [Q_WIDTH-1:0] r_q, r_x;

    // item
    logic               r_action;
    logic [7:0]         r_h;
    logic [Q_WIDTH-1:0] r_k;
    logic [31:0]        r_cr, r_cs;

    // working registers
    logic [P_WIDTH-1:0] r_base, r_acc, r_g1;
    logic [Q_WIDTH-1:0] r_exp;
    logic [ECW-1:0]     r_cnt;
    logic [Q_WIDTH-1:0] r_hq, r_rv, r_sv, r_t, r_w, r_u1, r_u2;

    // shared modular multiplier
    logic               r_busy, r_done;
    t_cmd               r_op;
    logic [DW-1:0]      r_mx, r_my, r_mm, r_macc;
    logic [MCW-1:0]     r_mcnt;

    logic               mm_start;
    logic [DW-1:0]      mx, my, mm;
    logic [DW-1:0]      one_p, one_q;
    logic [DW+1:0]      sum, d1, d2, m2;
    logic [DW-1:0]      mm_res;
    logic               mm_fin;
    logic [Q_WIDTH:0]   tsum, tred, s2, s2red, qx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p <= '0;
            r_q <= '0;
            r_a <= '0;
            r_x <= '0;
            r_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODULUS_P:       r_p <= i_cfg_data[P_WIDTH-1:0];
                CFG_ORDER_Q:         r_q <= i_cfg_data[Q_WIDTH-1:0];
                CFG_GENERATOR_A:     r_a <= i_cfg_data[P_WIDTH-1:0];
                CFG_OWN_SECRET_KEY:  r_x <= i_cfg_data[Q_WIDTH-1:0];
                CFG_PEER_PUBLIC_KEY: r_y <= i_cfg_data[P_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // 1 mod m
    assign one_p = (r_p <= P_WIDTH'(1)) ? '0 : DW'(1);
    assign one_q = (r_q <= Q_WIDTH'(1)) ? '0 : DW'(1);

    // operand select; y must already be below the modulus
    always_comb begin
        mm_start = 1'b1;
        mx       = '0;
        my       = '0;
        mm       = '0;
        case (i_cmd)
            CMD_POW_A_K, CMD_POW_A_U1: begin
                mx = DW'(r_a); my = one_p; mm = DW'(r_p);
            end
            CMD_POW_Y_U2: begin
                mx = DW'(r_y); my = one_p; mm = DW'(r_p);
            end
            CMD_POW_MUL: begin
                mx = DW'(r_acc); my = DW'(r_base); mm = DW'(r_p);
            end
            CMD_POW_SQR: begin
                mx = DW'(r_base); my = DW'(r_base); mm = DW'(r_p);
            end
            CMD_R_RED: begin
                mx = DW'(r_acc); my = one_q; mm = DW'(r_q);
            end
            CMD_HQ: begin
                mx = DW'(r_h); my = one_q; mm = DW'(r_q);
            end
            CMD_T1: begin
                mx = DW'(r_k); my = DW'(r_hq); mm = DW'(r_q);
            end
            CMD_T2: begin
                mx = DW'(r_x); my = DW'(r_rv); mm = DW'(r_q);
            end
            CMD_U1: begin
                mx = DW'(r_cs[Q_WIDTH-1:0]); my = DW'(r_w); mm = DW'(r_q);
            end
            CMD_U2: begin
                mx = DW'(r_cr[Q_WIDTH-1:0]); my = DW'(r_w); mm = DW'(r_q);
            end
            CMD_V: begin
                mx = DW'(r_g1); my = DW'(r_acc); mm = DW'(r_p);
            end
            CMD_VQ: begin
                mx = DW'(r_g1); my = one_q; mm = DW'(r_q);
            end
            default: mm_start = 1'b0;
        endcase
    end

    // one multiplier bit per cycle, MSB first: acc = 2*acc + bit*y mod m
    assign m2     = {2'b00, r_mm};
    assign sum    = {1'b0, r_macc, 1'b0} + (r_mx[DW-1] ? {2'b00, r_my} : '0);
    assign d1     = (sum >= m2) ? sum - m2 : sum;
    assign d2     = (d1 >= m2) ? d1 - m2 : d1;
    assign mm_fin = r_busy && (r_mcnt == MCW'(DW - 1));
    assign mm_res = (r_mm == '0) ? '0 : d2[DW-1:0];

    assign qx    = {1'b0, r_q};
    assign tsum  = {1'b0, r_t} + {1'b0, r_hq};
    assign tred  = (tsum >= qx) ? tsum - qx : tsum;
    assign s2    = {1'b0, r_t} + {1'b0, mm_res[Q_WIDTH-1:0]};
    assign s2red = (s2 >= qx) ? s2 - qx : s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (mm_start) begin
                r_busy <= 1'b1;
            end else if (mm_fin) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else if (i_cmd != CMD_NONE) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_action <= i_action;
            r_h      <= i_h;
            r_k      <= i_k;
            r_cr     <= i_cr;
            r_cs     <= i_cs;
        end

        if (mm_start) begin
            r_op   <= i_cmd;
            r_mx   <= mx;
            r_my   <= my;
            r_mm   <= mm;
            r_macc <= '0;
            r_mcnt <= '0;
        end else if (r_busy) begin
            r_mx   <= r_mx << 1;
            r_macc <= d2[DW-1:0];
            r_mcnt <= r_mcnt + MCW'(1);
        end

        case (i_cmd)
            CMD_POW_A_K: begin
                r_acc <= one_p[P_WIDTH-1:0];
                r_exp <= r_k;
                r_cnt <= '0;
            end
            CMD_POW_A_U1: begin
                r_acc <= one_p[P_WIDTH-1:0];
                r_exp <= r_u1;
                r_cnt <= '0;
            end
            CMD_POW_Y_U2: begin
                r_g1  <= r_acc;
                r_acc <= one_p[P_WIDTH-1:0];
                r_exp <= r_u2;
                r_cnt <= '0;
            end
            CMD_SRCH_INIT: begin
                r_t <= r_hq;
                r_w <= (r_q == Q_WIDTH'(1)) ? '0 : Q_WIDTH'(1);
            end
            CMD_SRCH_STEP: begin
                r_t <= tred[Q_WIDTH-1:0];
                r_w <= r_w + Q_WIDTH'(1);
            end
            CMD_FIN_SIGN: begin
                o_ok <= 1'b0;
                if (r_rv == '0 || r_sv == '0) begin
                    o_out_r <= '0;
                    o_out_s <= '0;
                    o_retry <= 1'b1;
                end else begin
                    o_out_r <= r_rv;
                    o_out_s <= r_sv;
                    o_retry <= 1'b0;
                end
            end
            CMD_FIN_RETRY: begin
                o_out_r <= '0;
                o_out_s <= '0;
                o_retry <= 1'b1;
                o_ok    <= 1'b0;
            end
            CMD_FIN_VFAIL: begin
                o_out_r <= '0;
                o_out_s <= '0;
                o_retry <= 1'b0;
                o_ok    <= 1'b0;
            end
            CMD_FIN_VER: begin
                o_out_r <= '0;
                o_out_s <= '0;
                o_retry <= 1'b0;
                o_ok    <= (32'(r_t) == r_cr);
            end
            default: ;
        endcase

        if (mm_fin) begin
            case (r_op)
                CMD_POW_A_K, CMD_POW_A_U1, CMD_POW_Y_U2:
                    r_base <= mm_res[P_WIDTH-1:0];
                CMD_POW_SQR: begin
                    r_base <= mm_res[P_WIDTH-1:0];
                    r_exp  <= r_exp >> 1;
                    r_cnt  <= r_cnt + ECW'(1);
                end
                CMD_POW_MUL: r_acc <= mm_res[P_WIDTH-1:0];
                CMD_R_RED:   r_rv  <= mm_res[Q_WIDTH-1:0];
                CMD_HQ:      r_hq  <= mm_res[Q_WIDTH-1:0];
                CMD_T1:      r_t   <= mm_res[Q_WIDTH-1:0];
                CMD_T2:      r_sv  <= s2red[Q_WIDTH-1:0];
                CMD_U1:      r_u1  <= mm_res[Q_WIDTH-1:0];
                CMD_U2:      r_u2  <= r_q - mm_res[Q_WIDTH-1:0];
                CMD_V:       r_g1  <= mm_res[P_WIDTH-1:0];
                CMD_VQ:      r_t   <= mm_res[Q_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign o_status.done     = r_done;
    assign o_status.exp_lsb  = r_exp[0];
    assign o_status.exp_done = (r_cnt == ECW'(Q_WIDTH));
    assign o_status.q_zero   = (r_q == '0);
    assign o_status.q_one    = (r_q == Q_WIDTH'(1));
    assign o_status.ver_bad  = (r_h == 8'd0) || (r_cr >= 32'(r_q)) || (r_cs >= 32'(r_q));
    assign o_status.t_one    = (r_t == Q_WIDTH'(1));
    assign o_status.w_last   = (r_w == r_q - Q_WIDTH'(1));
    assign o_status.action   = r_action;

endmodule

// ===== rtl/core/gsv_ctrl.sv =====
module gsv_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_valid,
    input  logic             i_m_ready,
    input  gsv_pkg::t_status i_status,
    output logic             o_s_ready,
    output logic             o_m_valid,
    output gsv_pkg::t_cmd    o_cmd
);
    import gsv_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_POW_START,
        ST_POW_CHK,
        ST_POW_MUL,
        ST_POW_SQR,
        ST_R_RED,
        ST_HQ,
        ST_T1,
        ST_T2,
        ST_SRCH_INIT,
        ST_SRCH_CHK,
        ST_SRCH_STEP,
        ST_U1,
        ST_U2,
        ST_V,
        ST_VQ,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        PW_SIGN,
        PW_G1,
        PW_G2
    } t_pow;

    t_state r_state, c_next;
    t_pow   r_pow;
    t_cmd   r_cmd, r_fin, c_cmd;
    logic   r_issued, r_out_valid;

    // command and follow-on state of the plain one-command states
    always_comb begin
        c_cmd  = CMD_NONE;
        c_next = ST_IDLE;
        case (r_state)
            ST_POW_START: begin
                c_next = ST_POW_CHK;
                case (r_pow)
                    PW_SIGN: c_cmd = CMD_POW_A_K;
                    PW_G1:   c_cmd = CMD_POW_A_U1;
                    default: c_cmd = CMD_POW_Y_U2;
                endcase
            end
            ST_POW_MUL:   begin c_cmd = CMD_POW_MUL;   c_next = ST_POW_SQR;  end
            ST_POW_SQR:   begin c_cmd = CMD_POW_SQR;   c_next = ST_POW_CHK;  end
            ST_R_RED:     begin c_cmd = CMD_R_RED;     c_next = ST_HQ;       end
            ST_HQ: begin
                c_cmd  = CMD_HQ;
                c_next = i_status.action ? ST_SRCH_INIT : ST_T1;
            end
            ST_T1:        begin c_cmd = CMD_T1;        c_next = ST_T2;       end
            ST_T2:        begin c_cmd = CMD_T2;        c_next = ST_FIN;      end
            ST_SRCH_INIT: begin c_cmd = CMD_SRCH_INIT; c_next = ST_SRCH_CHK; end
            ST_SRCH_STEP: begin c_cmd = CMD_SRCH_STEP; c_next = ST_SRCH_CHK; end
            ST_U1:        begin c_cmd = CMD_U1;        c_next = ST_U2;       end
            ST_U2:        begin c_cmd = CMD_U2;        c_next = ST_POW_START; end
            ST_V:         begin c_cmd = CMD_V;         c_next = ST_VQ;       end
            ST_VQ:        begin c_cmd = CMD_VQ;        c_next = ST_FIN;      end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pow       <= PW_SIGN;
            r_fin       <= CMD_FIN_VFAIL;
            r_cmd       <= CMD_NONE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmd <= CMD_NONE;
            if (r_out_valid && i_m_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_s_valid) begin
                        r_state <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH: begin
                    if (!i_status.action) begin
                        r_pow <= PW_SIGN;
                        if (i_status.q_zero) begin
                            r_fin   <= CMD_FIN_RETRY;
                            r_state <= ST_FIN;
                        end else begin
                            r_fin   <= CMD_FIN_SIGN;
                            r_state <= ST_POW_START;
                        end
                    end else begin
                        r_pow <= PW_G1;
                        if (i_status.q_zero || i_status.ver_bad) begin
                            r_fin   <= CMD_FIN_VFAIL;
                            r_state <= ST_FIN;
                        end else begin
                            r_fin   <= CMD_FIN_VER;
                            r_state <= ST_HQ;
                        end
                    end
                end
                ST_POW_CHK: begin
                    if (i_status.exp_done) begin
                        case (r_pow)
                            PW_SIGN: r_state <= ST_R_RED;
                            PW_G1: begin
                                r_pow   <= PW_G2;
                                r_state <= ST_POW_START;
                            end
                            default: r_state <= ST_V;
                        endcase
                    end else if (i_status.exp_lsb) begin
                        r_state <= ST_POW_MUL;
                    end else begin
                        r_state <= ST_POW_SQR;
                    end
                end
                ST_SRCH_CHK: begin
                    if (i_status.q_one || i_status.t_one) begin
                        r_state <= ST_U1;
                    end else if (i_status.w_last) begin
                        r_fin   <= CMD_FIN_VFAIL;
                        r_state <= ST_FIN;
                    end else begin
                        r_state <= ST_SRCH_STEP;
                    end
                end
                ST_FIN: begin
                    // load the output register only once the slot is free
                    if (!r_issued) begin
                        if (!r_out_valid || i_m_ready) begin
                            r_cmd    <= r_fin;
                            r_issued <= 1'b1;
                        end
                    end else if (i_status.done) begin
                        r_issued    <= 1'b0;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    if (!r_issued) begin
                        r_cmd    <= c_cmd;
                        r_issued <= 1'b1;
                    end else if (i_status.done) begin
                        r_issued <= 1'b0;
                        r_state  <= c_next;
                    end
                end
            endcase
        end
    end

    assign o_s_ready = (r_state == ST_IDLE);
    assign o_m_valid = r_out_valid;
    assign o_cmd     = r_cmd;

endmodule

// ===== rtl/core/gost_bytewise_sign_verify_core.sv =====
// GOST R 34.10-94 style sign / verify engine, one digest byte per item.
//
// Channels:
//   cfg  : i_cfg_valid/o_cfg_ready, index 0..4 = p, q, a, x, y. Write only
//          while the core is idle. Ready is always high.
//   s_axis: one transfer = one job. tuser[0] = action (0 sign, 1 verify).
//   m_axis: one result transfer per job.
// Operation: the core runs one job at a time on a single bit-serial modular
//   multiplier (one multiplier bit per cycle, DW = max(P_WIDTH, Q_WIDTH)).
//   An exponentiation is one multiply that reduces the base, then Q_WIDTH
//   square steps plus one multiply per set exponent bit. Verify: two
//   exponentiations plus a linear inverse search over at most q-1 candidates.
// s_axis_tready is high only while idle. The finished result sits in an
//   output register, so the next job is accepted while it waits; a job that
//   finishes while the previous result is still stalled holds until taken.
// Reset (synchronous, active low) clears all config registers to zero,
//   returns the controller to idle and drops m_axis_tvalid.
module gost_bytewise_sign_verify_core #(
    parameter int P_WIDTH = 31,
    parameter int Q_WIDTH = 11,
    localparam int IN_W  = ((8 + Q_WIDTH + 64 + 7) / 8) * 8,
    localparam int OUT_W = ((2 * Q_WIDTH + 2 + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gsv_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gsv_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // job in
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [IN_W-1:0]                 i_s_axis_tdata,  // digest_byte, nonce_k, check_r, check_s
    input  logic [0:0]                      i_s_axis_tuser,  // action
    // result out
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [OUT_W-1:0]                o_m_axis_tdata   // out_r, out_s, retry_needed, signature_ok
);
    import gsv_pkg::*;

    localparam int K_LO  = 8;
    localparam int CR_LO = K_LO + Q_WIDTH;
    localparam int CS_LO = CR_LO + 32;

    t_cmd               cmd;
    t_status            status;
    logic               in_fire;
    logic [Q_WIDTH-1:0] out_r, out_s;
    logic               retry, ok;

    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_s_axis_tvalid && o_s_axis_tready;

    gsv_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_status  (status),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .o_cmd     (cmd)
    );

    gsv_datapath #(
        .P_WIDTH (P_WIDTH),
        .Q_WIDTH (Q_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_load      (in_fire),
        .i_action    (i_s_axis_tuser[0]),
        .i_h         (i_s_axis_tdata[7:0]),
        .i_k         (i_s_axis_tdata[CR_LO-1:K_LO]),
        .i_cr        (i_s_axis_tdata[CS_LO-1:CR_LO]),
        .i_cs        (i_s_axis_tdata[CS_LO+31:CS_LO]),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_r     (out_r),
        .o_out_s     (out_s),
        .o_retry     (retry),
        .o_ok        (ok)
    );

    assign o_m_axis_tdata = OUT_W'({ok, retry, out_s, out_r});

    // a result is either a sign result or a verify verdict, never both
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(retry && ok))
        else $error("retry and signature_ok both set");

    // retry always comes with a zeroed pair
    a_retry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && retry) |-> (out_r == '0 && out_s == '0))
        else $error("retry with nonzero r/s");

    // an accepted job keeps the input closed on the next cycle
    a_one_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_s_axis_tready)
        else $error("input reopened right after accept");

endmodule

// ===== verif/gost_bytewise_sign_verify_core_test.sv =====
module gost_bytewise_sign_verify_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gsv_pkg::*;

    localparam int PW = 31;
    localparam int QW = 11;
    localparam longint unsigned P_MASK = (64'd1 << PW) - 1;
    localparam longint unsigned Q_MASK = (64'd1 << QW) - 1;
    // Mersenne prime 2^31-1; 7 generates its full multiplicative group
    localparam longint unsigned P_BIG = 64'd2147483647;

    localparam bit ACT_SIGN   = 1'b0;
    localparam bit ACT_VERIFY = 1'b1;

    // one result transfer, fields from the highest bit down
    typedef struct packed {
        logic          sig_ok;
        logic          retry;
        logic [QW-1:0] s;
        logic [QW-1:0] r;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic        job_valid = 1'b0;
    logic        job_ready;
    logic [87:0] job_data = '0;
    logic [0:0]  job_user = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [23:0] res_data;

    gost_bytewise_sign_verify_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (job_valid),
        .o_s_axis_tready (job_ready),
        .i_s_axis_tdata  (job_data),
        .i_s_axis_tuser  (job_user),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow copy of the key / group registers
    longint unsigned grp_p, grp_q, grp_a, key_x, key_y;

    t_verdict awaited_verdicts[$];
    int       errors    = 0;
    bit       calm      = 1'b0;   // no idling on either side while set
    int       hold_left = 0;      // receiver back-pressure cycles left

    function automatic longint unsigned mulmod(longint unsigned x, longint unsigned y,
                                               longint unsigned m);
        if (m == 0) return 0;
        return ((x % m) * (y % m)) % m;
    endfunction

    function automatic longint unsigned powmod(longint unsigned b, longint unsigned e,
                                               longint unsigned m);
        longint unsigned acc, base;
        if (m == 0) return 0;
        acc  = 1 % m;
        base = b % m;
        while (e != 0) begin
            if (e[0]) acc = mulmod(acc, base, m);
            base = mulmod(base, base, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    // extended Euclid; returns 0 when h has no inverse mod q
    function automatic bit invmod(longint unsigned h, longint unsigned q,
                                  output longint unsigned inv);
        longint r0, r1, t0, t1, qq, tmp;
        r0 = q; r1 = h % q; t0 = 0; t1 = 1;
        inv = 0;
        while (r1 != 0) begin
            qq = r0 / r1;
            tmp = r0 - qq * r1; r0 = r1; r1 = tmp;
            tmp = t0 - qq * t1; t0 = t1; t1 = tmp;
        end
        if (r0 != 1) return 1'b0;
        if (t0 < 0) t0 += q;
        inv = longint'(t0) % q;
        return 1'b1;
    endfunction

    function automatic t_verdict predict_verdict(bit act, logic [7:0] h, logic [QW-1:0] k,
                                                 logic [31:0] cr, logic [31:0] cs);
        t_verdict        v;
        longint unsigned r, s, w, u1, u2, t;
        v = '0;
        if (act == ACT_SIGN) begin
            if (grp_q == 0) begin
                v.retry = 1'b1;
                return v;
            end
            r = powmod(grp_a, k, grp_p) % grp_q;
            s = (mulmod(k, h, grp_q) + mulmod(key_x, r, grp_q)) % grp_q;
            if (r == 0 || s == 0) v.retry = 1'b1;
            else begin
                v.r = r[QW-1:0];
                v.s = s[QW-1:0];
            end
            return v;
        end
        // verify: range checks, zero digest and missing inverse all fail
        if (grp_q == 0 || h == 0 || cr >= grp_q || cs >= grp_q) return v;
        if (!invmod(h, grp_q, w)) return v;
        u1 = mulmod(cs, w, grp_q);
        u2 = grp_q - mulmod(cr, w, grp_q);
        t  = mulmod(powmod(grp_a, u1, grp_p), powmod(key_y, u2, grp_p), grp_p) % grp_q;
        v.sig_ok = (t == cr);
        return v;
    endfunction

    // result side: random ready, long hold-off on request, field checks
    always @(posedge i_clk) begin
        t_verdict got, want;
        if (!i_rst_n) begin
            res_ready <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                got = res_data;
                if (awaited_verdicts.size() == 0) begin
                    $display("%0t: unexpected result transfer %h", $time, res_data);
                    errors++;
                end else begin
                    want = awaited_verdicts.pop_front();
                    if (got.r !== want.r) begin
                        $display("%0t: out_r exp %0d got %0d", $time, want.r, got.r);
                        errors++;
                    end
                    if (got.s !== want.s) begin
                        $display("%0t: out_s exp %0d got %0d", $time, want.s, got.s);
                        errors++;
                    end
                    if (got.retry !== want.retry) begin
                        $display("%0t: retry_needed exp %0b got %0b", $time, want.retry,
                                 got.retry);
                        errors++;
                    end
                    if (got.sig_ok !== want.sig_ok) begin
                        $display("%0t: signature_ok exp %0b got %0b", $time, want.sig_ok,
                                 got.sig_ok);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                res_ready <= 1'b0;
            end else begin
                res_ready <= calm || ($urandom_range(99) >= 31);
            end
        end
    end

    // register write; only called with nothing in flight
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned value,
                             longint unsigned mask);
        // stop offering the last job again while the core goes idle
        job_valid <= 1'b0;
        while (awaited_verdicts.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        // junk above the register width must be dropped
        cfg_data  <= 32'((value & mask) | (32'($urandom) & ~32'(mask)));
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MODULUS_P:       grp_p = value & P_MASK;
            CFG_ORDER_Q:         grp_q = value & Q_MASK;
            CFG_GENERATOR_A:     grp_a = value & P_MASK;
            CFG_OWN_SECRET_KEY:  key_x = value & Q_MASK;
            CFG_PEER_PUBLIC_KEY: key_y = value & P_MASK;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_group(longint unsigned p, longint unsigned q, longint unsigned a,
                             longint unsigned x);
        write_reg(CFG_MODULUS_P, p, P_MASK);
        write_reg(CFG_ORDER_Q, q, Q_MASK);
        write_reg(CFG_GENERATOR_A, a, P_MASK);
        write_reg(CFG_OWN_SECRET_KEY, x, Q_MASK);
        write_reg(CFG_PEER_PUBLIC_KEY, powmod(a, x, p), P_MASK);
    endtask

    // subgroup of order q inside the 2^31-1 group
    task automatic set_big_group(longint unsigned q);
        set_group(P_BIG, q, powmod(7, (P_BIG - 1) / q, P_BIG), $urandom_range(q - 1, 1));
    endtask

    task automatic send_job(bit act, logic [7:0] h, logic [QW-1:0] k, logic [31:0] cr,
                            logic [31:0] cs);
        if (!calm && $urandom_range(99) < 31) begin
            job_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        job_valid <= 1'b1;
        job_user  <= act;
        job_data  <= {5'd0, cs, cr, k, h};
        do @(posedge i_clk); while (!job_ready);
        awaited_verdicts.push_back(predict_verdict(act, h, k, cr, cs));
    endtask

    // sign a digest byte, then verify it, now and then with a damaged word
    task automatic sign_then_verify(logic [7:0] h, logic [QW-1:0] k, bit spoil);
        t_verdict sg;
        logic [31:0] cr, cs;
        sg = predict_verdict(ACT_SIGN, h, k, '0, '0);
        send_job(ACT_SIGN, h, k, 32'($urandom), 32'($urandom));
        cr = sg.r;
        cs = sg.s;
        if (spoil) begin
            if ($urandom_range(1)) cr = $urandom_range(grp_q);
            else cs = $urandom_range(grp_q);
        end
        send_job(ACT_VERIFY, h, 11'($urandom), cr, cs);
    endtask

    task automatic random_job();
        send_job($urandom_range(1), 8'($urandom), 11'($urandom),
                 $urandom_range(1) ? 32'($urandom) : 32'($urandom_range(grp_q)),
                 $urandom_range(1) ? 32'($urandom) : 32'($urandom_range(grp_q)));
    endtask

    // all registers still zero after reset
    task automatic test_reset_state();
        grp_p = 0; grp_q = 0; grp_a = 0; key_x = 0; key_y = 0;
        send_job(ACT_SIGN, 8'd5, 11'd3, '0, '0);
        send_job(ACT_VERIFY, 8'd5, 11'd0, 32'd0, 32'd0);
    endtask

    // zero modulus with a nonzero order
    task automatic test_modulus_zero();
        set_group(0, 11, 2, 7);
        send_job(ACT_SIGN, 8'd9, 11'd4, '0, '0);
        send_job(ACT_VERIFY, 8'd9, 11'd0, 32'd1, 32'd1);
    endtask

    // p = 23, q = 11, a = 2: operand extremes and verify failure paths
    task automatic test_small_group();
        set_group(23, 11, 2, 7);
        send_job(ACT_SIGN, 8'd0, 11'd0, '0, '0);          // zero nonce
        send_job(ACT_SIGN, 8'd255, 11'd2047, '0, '0);     // nonce above q
        send_job(ACT_SIGN, 8'd255, 11'd11, '0, '0);       // nonce equal to q
        send_job(ACT_SIGN, 8'd1, 11'd1, '0, '0);
        sign_then_verify(8'd200, 11'd3, 1'b0);
        sign_then_verify(8'd255, 11'd10, 1'b0);
        send_job(ACT_VERIFY, 8'd0, 11'd0, 32'd3, 32'd3);              // zero digest
        send_job(ACT_VERIFY, 8'd22, 11'd0, 32'd3, 32'd3);             // no inverse
        send_job(ACT_VERIFY, 8'd5, 11'd0, 32'hFFFF_FFFF, 32'd3);      // r too large
        send_job(ACT_VERIFY, 8'd5, 11'd0, 32'd3, 32'hFFFF_FFFF);      // s too large
        send_job(ACT_VERIFY, 8'd5, 11'd0, 32'd11, 32'd10);            // r equal to q
        send_job(ACT_VERIFY, 8'd5, 11'd0, 32'd0, 32'd0);
        write_reg(CFG_ORDER_Q, 1, Q_MASK);                            // q = 1: signing always retries
        send_job(ACT_SIGN, 8'd7, 11'd5, '0, '0);
        send_job(ACT_VERIFY, 8'd7, 11'd0, 32'd0, 32'd0);
    endtask

    // widest operands; q = 2047 is composite, so inverses go missing
    task automatic test_wide_order();
        set_group(P_BIG, 2047, P_BIG - 1, 2047);
        write_reg(CFG_PEER_PUBLIC_KEY, P_BIG - 1, P_MASK);
        send_job(ACT_SIGN, 8'd255, 11'd2047, '0, '0);
        sign_then_verify(8'd100, 11'd2046, 1'b0);
        send_job(ACT_VERIFY, 8'd23, 11'd0, 32'd5, 32'd5);
        send_job(ACT_VERIFY, 8'd178, 11'd0, 32'd2046, 32'd2046);
    endtask

    // receiver stalls for a long time while jobs keep coming
    task automatic test_backpressure();
        set_big_group(11);
        hold_left = 5000;
        repeat (3) sign_then_verify(8'($urandom_range(255, 1)), 11'($urandom_range(10, 1)),
                                    1'b0);
    endtask

    task automatic test_random();
        int unsigned pick;
        longint unsigned qs[5] = '{7, 11, 31, 151, 331};
        for (int phase = 0; phase < 8; phase++) begin
            pick = $urandom_range(4);
            case (phase % 4)
                0: set_big_group(qs[pick]);
                1: set_group(23, 11, 2, $urandom_range(10, 1));
                2: set_big_group(qs[pick]);
                default: set_group($urandom, $urandom_range(400), $urandom, $urandom);
            endcase
            calm = (phase == 2);
            for (int n = 0; n < 18; n++) begin
                if ($urandom_range(99) < 65)
                    sign_then_verify(8'($urandom),
                                     $urandom_range(3) == 0 ? 11'($urandom)
                                                            : 11'($urandom_range(grp_q)),
                                     $urandom_range(99) < 25);
                else
                    random_job();
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_modulus_zero();
        test_small_group();
        test_wide_order();
        test_backpressure();
        test_random();
        job_valid <= 1'b0;
        while (awaited_verdicts.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("gost_bytewise_sign_verify_core_test OK");
        else
            $display("gost_bytewise_sign_verify_core_test NOT OK");
        $finish;
    end

    // run guard, several times the slowest legal run
    initial begin
        #40ms;
        $display("gost_bytewise_sign_verify_core_test NOT OK");
        $finish;
    end

endmodule
